@@ sv/cal_pkg.sv @@
// Package for the cursor array list: opcodes, status codes, FSM states and
// the control struct that the top level hands to every cell. No dependencies.
`timescale 1ns / 1ps

package cal_pkg;

    localparam int LEN_W       = 7;
    localparam int OP_W        = 4;
    localparam int ST_W        = 2;
    localparam int DEPTH_DEF   = 64;
    localparam int DATA_W_DEF  = 32;
    localparam int GRP         = 8;
    localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 4'd0,
        OP_INSERT = 4'd1,
        OP_APPEND = 4'd2,
        OP_REMOVE = 4'd3,
        OP_START  = 4'd4,
        OP_END    = 4'd5,
        OP_PREV   = 4'd6,
        OP_NEXT   = 4'd7,
        OP_MOVE   = 4'd8,
        OP_READ   = 4'd9
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOELEM = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_APPEND = 2'd2,
        SH_REMOVE = 2'd3
    } shift_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_GATHER = 2'd2
    } state_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        shift_t             shift;
        logic [LEN_W-1:0]   cursor;
        logic [LEN_W-1:0]   count;
    } ctrl_t;

endpackage

@@ sv/cal_in_if.sv @@
// Request channel of the cursor array list: valid/ready plus opcode, value
// and position. Depends on cal_pkg.
`timescale 1ns / 1ps

interface cal_in_if #(
    parameter int DATA_WIDTH = cal_pkg::DATA_W_DEF
);
    logic                         valid;
    logic                         ready;
    logic [cal_pkg::OP_W-1:0]     opcode;
    logic [DATA_WIDTH-1:0]        value;
    logic [cal_pkg::LEN_W-1:0]    position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink   (input valid, opcode, value, position, output ready);
endinterface

@@ sv/cal_out_if.sv @@
// Result channel of the cursor array list: valid/ready plus read value,
// status, length and cursor. Depends on cal_pkg.
`timescale 1ns / 1ps

interface cal_out_if #(
    parameter int DATA_WIDTH = cal_pkg::DATA_W_DEF
);
    logic                         valid;
    logic                         ready;
    logic [DATA_WIDTH-1:0]        read_value;
    logic [cal_pkg::ST_W-1:0]     status;
    logic [cal_pkg::LEN_W-1:0]    length;
    logic [cal_pkg::LEN_W-1:0]    cursor;

    modport source (output valid, read_value, status, length, cursor, input ready);
    modport sink   (input valid, read_value, status, length, cursor, output ready);
endinterface

@@ sv/cursor_array_list.sv @@
// Top level of the cursor array list: control FSM, cell chain and read
// gather tree. Depends on cal_pkg, cal_in_if, cal_out_if and cal_cell.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// req       in   valid/ready        opcode[3:0], value[DATA_WIDTH-1:0], position[6:0]
// rsp       out  valid/ready        read_value, status[1:0], length[6:0], cursor[6:0]
// cfg       in   cfg_we             cfg_wdata[6:0] -> capacity
//
// Each item passes through three steps: accept, execute (every cell shifts at once
// and the cells of each group of eight OR their cursor-selected word into a
// register), gather (the group words are ORed into the result register).
// An item is accepted while an earlier result still waits in the result
// register; gather holds until that register is free.
// Reset clears length, cursor, capacity (to 64) and the FSM; entry words are
// left as they are, since only entries below the length are ever read.

module cursor_array_list #(
    parameter int DEPTH      = cal_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cal_pkg::DATA_W_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cal_in_if.sink                     req,
    cal_out_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [cal_pkg::LEN_W-1:0]  cfg_wdata
);

    localparam int LW      = cal_pkg::LEN_W;
    localparam int NGRP    = (DEPTH + cal_pkg::GRP - 1) / cal_pkg::GRP;
    localparam int LIM_MAX = (DEPTH > 127) ? 127 : DEPTH;
    localparam logic [LW-1:0] DEPTH_LIM = LW'(LIM_MAX);

    // FSM and list state
    cal_pkg::state_t          state_reg, state_next;
    logic [LW-1:0]            count_reg, count_next;
    logic [LW-1:0]            cursor_reg, cursor_next;
    logic [LW-1:0]            capacity_reg;

    // latched request
    logic [cal_pkg::OP_W-1:0] op_reg;
    logic [DATA_WIDTH-1:0]    value_reg;
    logic [LW-1:0]            pos_reg;

    // per-item result bookkeeping
    cal_pkg::status_t         status_reg, status_next;
    logic                     rd_ok_reg, rd_ok_next;

    // result register
    logic                     rsp_valid_reg;
    logic [DATA_WIDTH-1:0]    rsp_data_reg;
    cal_pkg::status_t         rsp_status_reg;
    logic [LW-1:0]            rsp_len_reg;
    logic [LW-1:0]            rsp_cur_reg;

    logic [LW-1:0]            limit;
    logic                     full;
    logic                     at_end;
    cal_pkg::ctrl_t           ctrl;
    logic                     slot_free;
    logic                     load_rsp;
    logic [DATA_WIDTH-1:0]    gather;

    logic [DATA_WIDTH-1:0]    cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]    cell_sel  [DEPTH];
    logic [DATA_WIDTH-1:0]    grp_reg   [NGRP];
    logic [DATA_WIDTH-1:0]    grp_next  [NGRP];

    // Limit is the smaller of capacity and the chain depth.
    assign limit  = (capacity_reg > DEPTH_LIM) ? DEPTH_LIM : capacity_reg;
    assign full   = (count_reg >= limit);
    assign at_end = (cursor_reg >= count_reg);

    assign req.ready = (state_reg == cal_pkg::S_IDLE);
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign load_rsp  = (state_reg == cal_pkg::S_GATHER) && slot_free;

    // Next state, list update and cell commands.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        ctrl.shift  = cal_pkg::SH_HOLD;
        ctrl.cursor = cursor_reg;
        ctrl.count  = count_reg;

        unique case (state_reg)
            cal_pkg::S_IDLE:
            begin
                if (req.valid)
                    state_next = cal_pkg::S_EXEC;
            end
            cal_pkg::S_EXEC:
            begin
                state_next  = cal_pkg::S_GATHER;
                status_next = cal_pkg::ST_OK;
                rd_ok_next  = 1'b0;
                unique case (cal_pkg::opcode_t'(op_reg))
                    cal_pkg::OP_CLEAR:
                    begin
                        count_next  = '0;
                        cursor_next = '0;
                    end
                    cal_pkg::OP_INSERT:
                    begin
                        if (full)
                            status_next = cal_pkg::ST_FULL;
                        else
                        begin
                            ctrl.shift = cal_pkg::SH_INSERT;
                            count_next = count_reg + LW'(1);
                        end
                    end
                    cal_pkg::OP_APPEND:
                    begin
                        if (full)
                            status_next = cal_pkg::ST_FULL;
                        else
                        begin
                            ctrl.shift = cal_pkg::SH_APPEND;
                            count_next = count_reg + LW'(1);
                        end
                    end
                    cal_pkg::OP_REMOVE:
                    begin
                        if (at_end)
                            status_next = cal_pkg::ST_NOELEM;
                        else
                        begin
                            ctrl.shift = cal_pkg::SH_REMOVE;
                            count_next = count_reg - LW'(1);
                            rd_ok_next = 1'b1;
                        end
                    end
                    cal_pkg::OP_START:
                    begin
                        cursor_next = '0;
                    end
                    cal_pkg::OP_END:
                    begin
                        cursor_next = (count_reg == '0) ? '0 : count_reg - LW'(1);
                    end
                    cal_pkg::OP_PREV:
                    begin
                        if (cursor_reg != '0)
                            cursor_next = cursor_reg - LW'(1);
                    end
                    cal_pkg::OP_NEXT:
                    begin
                        if (cursor_reg < count_reg)
                            cursor_next = cursor_reg + LW'(1);
                    end
                    cal_pkg::OP_MOVE:
                    begin
                        if (pos_reg > count_reg)
                            status_next = cal_pkg::ST_RANGE;
                        else
                            cursor_next = pos_reg;
                    end
                    cal_pkg::OP_READ:
                    begin
                        if (at_end)
                            status_next = cal_pkg::ST_NOELEM;
                        else
                            rd_ok_next = 1'b1;
                    end
                    default:
                    begin
                        status_next = cal_pkg::ST_OK;
                    end
                endcase
            end
            cal_pkg::S_GATHER:
            begin
                // hold until the result register can take the item
                if (slot_free)
                    state_next = cal_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cal_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cal_pkg::S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            capacity_reg  <= cal_pkg::CAP_RESET;
            status_reg    <= cal_pkg::ST_OK;
            rd_ok_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Latch the request on acceptance.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg    <= req.opcode;
            value_reg <= req.value;
            pos_reg   <= req.position;
        end
    end

    // The chain of cells: every entry moves in the same cycle.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        cal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (value_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .sel_data   (cell_sel[i])
        );
    end

    // First level of the read tree: OR each group of eight cells. Only the
    // cell at the cursor drives a non-zero word, and it is captured before
    // any shift lands.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < cal_pkg::GRP; k++)
            begin
                if (g * cal_pkg::GRP + k < DEPTH)
                    grp_next[g] = grp_next[g] | cell_sel[g * cal_pkg::GRP + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == cal_pkg::S_EXEC)
        begin
            for (int g = 0; g < NGRP; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    // Second level: OR the group words.
    always_comb
    begin
        gather = '0;
        for (int g = 0; g < NGRP; g++)
            gather = gather | grp_reg[g];
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_data_reg   <= rd_ok_reg ? gather : '0;
            rsp_status_reg <= status_reg;
            rsp_len_reg    <= count_reg;
            rsp_cur_reg    <= cursor_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_data_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.length     = rsp_len_reg;
    assign rsp.cursor     = rsp_cur_reg;

    // Checks on the control logic.
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond list length");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == cal_pkg::S_EXEC))
        else $error("accepted item did not enter execute");

    a_exec_gather: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cal_pkg::S_EXEC) |=> (state_reg == cal_pkg::S_GATHER))
        else $error("execute did not move to gather");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cal_pkg::S_EXEC && status_next == cal_pkg::ST_FULL)
        |=> $stable(count_reg) && $stable(cursor_reg))
        else $error("full request changed the list");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !load_rsp)
        else $error("pending result overwritten");

endmodule

@@ sv/cal_cell.sv @@
// One entry of the list chain: holds a word and takes it from the left
// neighbour, the right neighbour or the new value. Depends on cal_pkg.
`timescale 1ns / 1ps

module cal_cell #(
    parameter int          DATA_WIDTH = cal_pkg::DATA_W_DEF,
    parameter int unsigned INDEX      = 0
) (
    input  logic                  clk,
    input  cal_pkg::ctrl_t        ctrl,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] sel_data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [31:0]           cur;
    logic [31:0]           cnt;

    assign cur = 32'(ctrl.cursor);
    assign cnt = 32'(ctrl.count);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.shift)
            cal_pkg::SH_INSERT:
            begin
                if (INDEX == cur)
                    data_next = value;
                else if (INDEX > cur && INDEX <= cnt)
                    data_next = left_data;
            end
            cal_pkg::SH_APPEND:
            begin
                if (INDEX == cnt)
                    data_next = value;
            end
            cal_pkg::SH_REMOVE:
            begin
                // pull the right neighbour into the gap
                if (INDEX >= cur && INDEX + 1 < cnt)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (INDEX == cur) ? data_reg : '0;

endmodule

@@ bench/tb_cursor_array_list.sv @@
// Self-checking bench for cursor_array_list: directed probe table, then random
// list traffic under several capacity settings. Depends on cal_pkg, cal_in_if,
// cal_out_if and the cursor_array_list RTL.
`timescale 1ns / 1ps

module tb_cursor_array_list;

    localparam int OP_W           = cal_pkg::OP_W;
    localparam int LEN_W          = cal_pkg::LEN_W;
    localparam int DW             = cal_pkg::DATA_W_DEF;
    localparam int LIST_DEPTH     = cal_pkg::DEPTH_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DIRECTED_CAP   = 2;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 85;
    localparam int RANDOM_CAP_PHASE = 5;

    // Opcodes 10 to 15 have no meaning; the block must leave the list alone.
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd10;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;

    // Traffic profiles: how strongly a phase pushes the list towards full or
    // empty. Weights are in percent, ordered by opcode encoding, with the
    // last slot standing for the undefined opcodes.
    localparam int PROF_GROW   = 0;
    localparam int PROF_MIXED  = 1;
    localparam int PROF_SHRINK = 2;
    localparam int UNDEF_SLOT  = 10;
    localparam int unsigned OP_MIX [3][11] = '{
        '{0, 30, 30,  8, 3, 3, 5, 5,  6,  8, 2},
        '{2, 16, 16, 16, 4, 4, 6, 6, 10, 16, 4},
        '{0,  5,  5, 40, 4, 4, 6, 6, 10, 16, 4}
    };

    // Grow first so the list reaches its full depth, then drop the capacity
    // below the length, try zero and one, and finish with a quiet phase.
    localparam int PHASE_CAP  [NUM_PHASES] = '{64, 127, 5, 0, 1, 0, 64, 8, 100, 64};
    localparam int PHASE_PROF [NUM_PHASES] = '{
        PROF_GROW, PROF_GROW, PROF_SHRINK, PROF_MIXED, PROF_MIXED,
        PROF_GROW, PROF_GROW, PROF_SHRINK, PROF_MIXED, PROF_MIXED
    };

    typedef struct packed {
        logic [DW-1:0]     read_value;
        cal_pkg::status_t  status;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  cursor;
    } list_result_t;

    // One row of the directed probe; typed rows carry their own expectation.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DW-1:0]     val;
        logic [LEN_W-1:0]  pos;
        bit                typed;
        logic [DW-1:0]     e_rv;
        cal_pkg::status_t  e_st;
        logic [LEN_W-1:0]  e_len;
        logic [LEN_W-1:0]  e_cur;
    } probe_row_t;

    // Walked with capacity 2 straight after reset.
    probe_row_t directed_rows [0:24] = '{
        '{cal_pkg::OP_READ,   32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_NOELEM, 7'd0, 7'd0},
        '{cal_pkg::OP_REMOVE, 32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_NOELEM, 7'd0, 7'd0},
        '{cal_pkg::OP_END,    32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_PREV,   32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_NEXT,   32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_MOVE,   32'h0,        7'd1,   1'b1, 32'h0, cal_pkg::ST_RANGE,  7'd0, 7'd0},
        '{cal_pkg::OP_MOVE,   32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_INSERT, 32'hFFFFFFFF, 7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_APPEND, 32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_APPEND, 32'h5A5A5A5A, 7'd0,   1'b1, 32'h0, cal_pkg::ST_FULL,   7'd2, 7'd0},
        '{cal_pkg::OP_INSERT, 32'h00000001, 7'd0,   1'b1, 32'h0, cal_pkg::ST_FULL,   7'd2, 7'd0},
        '{cal_pkg::OP_READ,   32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_NEXT,   32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_READ,   32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_END,    32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_MOVE,   32'h0,        7'd127, 1'b1, 32'h0, cal_pkg::ST_RANGE,  7'd2, 7'd1},
        '{cal_pkg::OP_MOVE,   32'h0,        7'd2,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_READ,   32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_NOELEM, 7'd2, 7'd2},
        '{cal_pkg::OP_PREV,   32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_REMOVE, 32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_REMOVE, 32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_NOELEM, 7'd1, 7'd1},
        '{OP_UNDEF_HI,        32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_OK,     7'd1, 7'd1},
        '{OP_UNDEF_LO,        32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_START,  32'h0,        7'd0,   1'b0, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0},
        '{cal_pkg::OP_CLEAR,  32'h0,        7'd0,   1'b1, 32'h0, cal_pkg::ST_OK,     7'd0, 7'd0}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    cal_in_if  req_if ();
    cal_out_if rsp_if ();

    cursor_array_list i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the list: contents, length, cursor and the capacity register.
    logic [DW-1:0]    list_mem [0:LIST_DEPTH-1];
    int unsigned      list_len;
    int unsigned      list_cur;
    logic [LEN_W-1:0] cap_reg;

    list_result_t pending_results [$];

    bit          quiet_run;
    int unsigned sender_calm;
    int unsigned idle_run     = 0;
    int unsigned error_count  = 0;
    int unsigned items_sent;
    int unsigned results_seen = 0;
    int unsigned cap_writes;
    int unsigned n_full       = 0;
    int unsigned n_noelem     = 0;
    int unsigned n_range      = 0;

    // Apply one operation to the shadow list and return what the block owes.
    function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
                                                input logic [DW-1:0] val,
                                                input logic [LEN_W-1:0] pos);
        list_result_t r;
        int unsigned  lim;
        int unsigned  i;
        r.read_value = '0;
        r.status     = cal_pkg::ST_OK;
        lim = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : cap_reg;
        case (op)
            cal_pkg::OP_CLEAR:
            begin
                list_len = 0;
                list_cur = 0;
            end
            cal_pkg::OP_INSERT:
            begin
                if (list_len >= lim)
                    r.status = cal_pkg::ST_FULL;
                else
                begin
                    for (i = list_len; i > list_cur; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[list_cur] = val;
                    list_len++;
                end
            end
            cal_pkg::OP_APPEND:
            begin
                if (list_len >= lim)
                    r.status = cal_pkg::ST_FULL;
                else
                begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            cal_pkg::OP_REMOVE:
            begin
                if (list_cur >= list_len)
                    r.status = cal_pkg::ST_NOELEM;
                else
                begin
                    r.read_value = list_mem[list_cur];
                    for (i = list_cur; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            cal_pkg::OP_START:
                list_cur = 0;
            cal_pkg::OP_END:
                list_cur = (list_len == 0) ? 0 : list_len - 1;
            cal_pkg::OP_PREV:
            begin
                if (list_cur != 0)
                    list_cur--;
            end
            cal_pkg::OP_NEXT:
            begin
                if (list_cur < list_len)
                    list_cur++;
            end
            cal_pkg::OP_MOVE:
            begin
                if (pos > list_len)
                    r.status = cal_pkg::ST_RANGE;
                else
                    list_cur = pos;
            end
            cal_pkg::OP_READ:
            begin
                if (list_cur >= list_len)
                    r.status = cal_pkg::ST_NOELEM;
                else
                    r.read_value = list_mem[list_cur];
            end
            default:
            begin
            end
        endcase
        r.length = list_len[LEN_W-1:0];
        r.cursor = list_cur[LEN_W-1:0];
        return r;
    endfunction

    // Clock: 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one item at the falling edge, hold it until the block takes it,
    // then queue what the block should answer. Valid stays high on return so
    // that the next item can follow without a gap.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DW-1:0] val,
                             input logic [LEN_W-1:0] pos, input bit typed,
                             input list_result_t typed_result);
        list_result_t r;
        @(negedge clk);
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.value    <= val;
        req_if.position <= pos;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        r = list_apply(op, val, pos);
        pending_results.push_back(typed ? typed_result : r);
        items_sent++;
    endtask

    // Drop valid for a random burst now and then; hold off entirely during
    // calm stretches and in the quiet phase at the end.
    task automatic maybe_pause();
        int unsigned n;
        if (quiet_run)
            return;
        if (sender_calm > 0)
            sender_calm--;
        else if ($urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 18);
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        else if ($urandom_range(0, 19) == 0)
            sender_calm = $urandom_range(15, 60);
    endtask

    // Stop sending, let every owed result arrive, then let the block settle.
    task automatic drain_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the capacity register; only ever called with the block idle.
    task automatic write_capacity(input logic [LEN_W-1:0] cap);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cap_reg    = cap;
        cap_writes++;
    endtask

    // Result side: stall in random bursts, with calm stretches in between.
    initial
    begin
        int unsigned calm;
        int unsigned burst;
        calm = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet_run || calm > 0)
            begin
                rsp_if.ready <= 1'b1;
                if (calm > 0)
                    calm--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                rsp_if.ready <= 1'b0;
                burst = $urandom_range(1, 18);
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 15) == 0)
                    calm = $urandom_range(20, 80);
            end
        end
    end

    // Compare every accepted result with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_seen++;
            case (rsp_if.status)
                cal_pkg::ST_FULL:   n_full++;
                cal_pkg::ST_NOELEM: n_noelem++;
                cal_pkg::ST_RANGE:  n_range++;
                default:            ;
            endcase
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: read_value %h status %0d",
                       rsp_if.read_value, rsp_if.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value,
                           rsp_if.read_value);
                    error_count++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, rsp_if.length);
                    error_count++;
                end
                if (rsp_if.cursor !== want.cursor)
                begin
                    $error("cursor: expected %0d, got %0d", want.cursor, rsp_if.cursor);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_run <= 0;
            else if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_run <= idle_run + 1;
        end
    end

    // Main sequence: reset, directed probe, then the random phases.
    initial
    begin
        list_result_t     typed_result;
        logic [OP_W-1:0]  op;
        logic [DW-1:0]    val;
        logic [LEN_W-1:0] pos;
        int unsigned      roll;
        int unsigned      acc;
        int unsigned      slot;
        int unsigned      prof;
        int unsigned      cap;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_if.valid    = 1'b0;
        req_if.opcode   = '0;
        req_if.value    = '0;
        req_if.position = '0;
        quiet_run       = 1'b0;
        sender_calm     = 0;
        items_sent      = 0;
        cap_writes      = 0;
        list_len        = 0;
        list_cur        = 0;
        cap_reg         = cal_pkg::CAP_RESET;

        // Hold reset, then release it away from the rising edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed probe with a tiny capacity so full is reached at once.
        write_capacity(LEN_W'(DIRECTED_CAP));
        foreach (directed_rows[i])
        begin
            typed_result.read_value = directed_rows[i].e_rv;
            typed_result.status     = directed_rows[i].e_st;
            typed_result.length     = directed_rows[i].e_len;
            typed_result.cursor     = directed_rows[i].e_cur;
            maybe_pause();
            send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].pos,
                      directed_rows[i].typed, typed_result);
        end
        drain_results();

        // Random phases; the list carries over from one phase to the next, so
        // a lowered capacity often finds the list already longer than allowed.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            cap  = (ph == RANDOM_CAP_PHASE) ? $urandom_range(2, 63) : PHASE_CAP[ph];
            prof = PHASE_PROF[ph];
            write_capacity(cap[LEN_W-1:0]);
            quiet_run = (ph == NUM_PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Walk the weight table; slot index equals the opcode encoding.
                roll = $urandom_range(0, 99);
                slot = 0;
                acc  = OP_MIX[prof][0];
                while (roll >= acc)
                begin
                    slot++;
                    acc += OP_MIX[prof][slot];
                end
                if (slot == UNDEF_SLOT)
                    op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
                else
                    op = cal_pkg::opcode_t'(slot);

                // Favour the edge values of the data now and then.
                roll = $urandom_range(0, 15);
                if (roll == 0)
                    val = '0;
                else if (roll == 1)
                    val = '1;
                else
                    val = $urandom;

                // Mostly land near the current length; sometimes anywhere.
                if ($urandom_range(0, 3) != 0)
                    pos = LEN_W'($urandom_range(0, list_len + 1));
                else
                    pos = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));

                maybe_pause();
                send_item(op, val, pos, 1'b0, '0);
            end
            drain_results();
        end

        $display("Run covered %0d items and %0d results over %0d capacity writes.",
                 items_sent, results_seen, cap_writes);
        $display("Errors reported by the block: %0d full, %0d no element, %0d out of range.",
                 n_full, n_noelem, n_range);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ cursor_array_list.f @@
sv/cal_pkg.sv
sv/cal_in_if.sv
sv/cal_out_if.sv
sv/cal_cell.sv
sv/cursor_array_list.sv
bench/tb_cursor_array_list.sv
